>>> rtl/core/tcce_pkg.sv
// Shared types, widths and codes of the text console cursor engine.
// No dependencies; imported by every module of the block.
package tcce_pkg;

   localparam int CharW    = 8;
   localparam int CoordW   = 12;
   localparam int ScaleW   = 5;
   localparam int CurW     = 16;
   localparam int PixW     = 16;
   localparam int GlyphW   = 8;
   localparam int ScrollW  = 6;
   localparam int LhW      = 7;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;
   localparam int DivNumW  = 16;
   localparam int DivDenW  = 12;
   localparam int RspDataW = 48;

   localparam logic [CharW-1:0] CHAR_NUL       = 8'd0;
   localparam logic [CharW-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CharW-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CharW-1:0] CHAR_SPACE     = 8'd32;

   localparam logic [CsrIdxW-1:0] REG_ORIGIN_X      = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_ORIGIN_Y      = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_AREA_WIDTH    = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_AREA_HEIGHT   = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_GLYPH_SCALE   = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_START_CURSOR  = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_START_PROTECT = 3'd6;

   localparam logic [CoordW-1:0] AREA_WIDTH_RESET  = 12'd1024;
   localparam logic [CoordW-1:0] AREA_HEIGHT_RESET = 12'd768;
   localparam logic [ScaleW-1:0] GLYPH_SCALE_RESET = 5'd1;

   localparam logic [ScrollW-1:0] SCROLL_MAX = 6'd63;

   typedef enum logic [1:0] {
      CH_NUL,
      CH_BACKSPACE,
      CH_NEWLINE,
      CH_PRINT
   } char_class_type;

   typedef enum logic [1:0] {
      DIV_SEL_CPL,
      DIV_SEL_VL,
      DIV_SEL_POS
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CPL,
      ST_VL,
      ST_POS1_START,
      ST_POS1,
      ST_POS2_START,
      ST_POS2,
      ST_EMIT_DRAW,
      ST_EMIT_SCROLL
   } state_type;

   typedef struct packed {
      logic        load_char;
      logic        div_start;
      div_sel_type div_sel;
      logic        latch_cpl;
      logic        latch_vl;
      logic        cur_dec;
      logic        cur_inc;
      logic        cur_newline;
      logic        calc_draw;
      logic        latch_scroll;
      logic        load_draw;
      logic        load_scroll;
   } ctrl_cmd_type;

   typedef struct packed {
      char_class_type req_class;
      char_class_type cur_class;
      logic           div_done;
      logic           erase_ok;
      logic           scroll_hit;
      logic           scroll_pending;
      logic           out_free;
   } ctrl_sts_type;

   function automatic char_class_type classify(input logic [CharW-1:0] c);
      char_class_type k;
      if (c == CHAR_NUL) begin
         k = CH_NUL;
      end else if (c == CHAR_BACKSPACE) begin
         k = CH_BACKSPACE;
      end else if (c == CHAR_NEWLINE) begin
         k = CH_NEWLINE;
      end else begin
         k = CH_PRINT;
      end
      return k;
   endfunction

endpackage

>>> rtl/core/text_console_cursor_engine_core.sv
// Text console cursor engine: per byte, 0 to 2 draw/scroll transactions.
// A zero byte is accepted and dropped while the engine stays idle; a refused backspace
// frees the input after the line-geometry divides; an erase presents a draw; a printable
// byte presents a draw, followed by any scroll once the draw is taken; a newline presents
// only a scroll, if any; outputs wait on rsp_tready. One byte is in work at a time, and
// up to four divider passes set the rate. Reset is synchronous.
module text_console_cursor_engine_core import tcce_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [CharW-1:0]    req_tdata,   // [7:0] char_code
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [15:0] pixel_x, [31:16] pixel_y, [39:32] glyph, [45:40] scroll_pixels
   output logic [RspDataW-1:0] rsp_tdata,
   output logic                rsp_tuser,   // [0] command_kind
   output logic                rsp_tlast    // last_of_run
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   tcce_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tcce_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_char   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

>>> rtl/core/tcce_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all divides.
// Depends on tcce_pkg for operand widths.
module tcce_divider import tcce_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DivNumW-1:0] dividend,
   input  logic [DivDenW-1:0] divisor,
   output logic               done,
   output logic [DivNumW-1:0] quotient,
   output logic [DivDenW-1:0] remainder
);

   localparam int CntW = $clog2(DivNumW);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [DivNumW-1:0] quo_ff, quo_in;
   logic [DivDenW-1:0] rem_ff, rem_in;
   logic [DivDenW-1:0] div_ff, div_in;
   logic [DivDenW:0]   trial;
   logic [DivDenW:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DivNumW-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DivDenW-1:0];
            quo_in = {quo_ff[DivNumW-2:0], 1'b1};
         end else begin
            rem_in = trial[DivDenW-1:0];
            quo_in = {quo_ff[DivNumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(DivNumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

>>> rtl/core/tcce_datapath.sv
// Datapath: configuration registers, cursor and mark, line geometry,
// pixel math and the result register. Uses tcce_pkg and tcce_divider.
module tcce_datapath import tcce_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic [CharW-1:0]    req_char,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,
   output logic                rsp_tuser,
   output logic                rsp_tlast,
   input  ctrl_cmd_type        cmd,
   output ctrl_sts_type        sts
);

   logic [CoordW-1:0]  origin_x_ff, origin_y_ff, area_width_ff, area_height_ff;
   logic [ScaleW-1:0]  scale_ff;
   logic [CurW-1:0]    cursor_ff, cursor_in;
   logic [CurW-1:0]    mark_ff, mark_in;
   logic [CharW-1:0]   char_ff;
   logic [CoordW-1:0]  cpl_ff;
   logic [CoordW-1:0]  vl_ff;
   logic               scroll_ff;
   logic [PixW-1:0]    px_ff, py_ff;
   logic [GlyphW-1:0]  glyph_ff;

   logic               out_valid_ff;
   logic               out_kind_ff;
   logic               out_last_ff;
   logic [PixW-1:0]    out_px_ff, out_py_ff;
   logic [GlyphW-1:0]  out_glyph_ff;
   logic [ScrollW-1:0] out_sp_ff;

   logic [ScaleW-1:0]  scale_eff;
   logic [LhW-1:0]     lh;
   logic [ScrollW-1:0] sp;
   logic [DivNumW-1:0] div_num;
   logic [DivDenW-1:0] div_den;
   logic               div_done;
   logic [DivNumW-1:0] div_quo;
   logic [DivDenW-1:0] div_rem;
   logic [16:0]        prod_x;
   logic [17:0]        sum_x;
   logic [22:0]        prod_y;
   logic [23:0]        sum_y;
   logic [CurW:0]      nl_sum;
   logic [CurW:0]      line_next;
   logic               out_free;

   assign scale_eff = (scale_ff == '0) ? ScaleW'(1) : scale_ff;
   assign lh        = {1'b0, scale_eff, 1'b0} + LhW'(2);
   assign sp        = (lh > LhW'(SCROLL_MAX)) ? SCROLL_MAX : lh[ScrollW-1:0];

   always_comb begin
      unique case (cmd.div_sel)
         DIV_SEL_CPL: begin
            div_num = DivNumW'(area_width_ff);
            div_den = DivDenW'(scale_eff);
         end
         DIV_SEL_VL: begin
            div_num = DivNumW'(area_height_ff);
            div_den = DivDenW'(lh);
         end
         default: begin
            div_num = cursor_ff;
            div_den = cpl_ff;
         end
      endcase
   end

   tcce_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // pixel position of the cell named by the last position divide
   assign prod_x = 17'(scale_eff) * 17'(div_rem);
   assign sum_x  = 18'(prod_x) + 18'(origin_x_ff);
   assign prod_y = 23'(lh) * 23'(div_quo);
   assign sum_y  = 24'(prod_y) + 24'(origin_y_ff);

   assign nl_sum    = {1'b0, cursor_ff} + 17'(cpl_ff - div_rem);
   assign line_next = {1'b0, div_quo} + 17'd1;
   assign out_free  = !out_valid_ff || rsp_tready;

   always_comb begin
      cursor_in = cursor_ff;
      mark_in   = mark_ff;
      if (csr_we && csr_index == REG_START_CURSOR) begin
         cursor_in = csr_wdata;
      end else if (cmd.cur_dec) begin
         cursor_in = cursor_ff - 1'b1;
      end else if (cmd.cur_inc) begin
         cursor_in = (cursor_ff == '1) ? cursor_ff : cursor_ff + 1'b1;
      end else if (cmd.cur_newline) begin
         cursor_in = nl_sum[CurW] ? '1 : nl_sum[CurW-1:0];
      end else if (cmd.load_scroll) begin
         cursor_in = (cursor_ff >= CurW'(cpl_ff)) ? cursor_ff - CurW'(cpl_ff) : '0;
      end
      if (csr_we && csr_index == REG_START_PROTECT) begin
         mark_in = csr_wdata;
      end else if (cmd.load_scroll) begin
         mark_in = (mark_ff >= CurW'(cpl_ff)) ? mark_ff - CurW'(cpl_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         area_width_ff  <= AREA_WIDTH_RESET;
         area_height_ff <= AREA_HEIGHT_RESET;
         scale_ff       <= GLYPH_SCALE_RESET;
         cursor_ff      <= '0;
         mark_ff        <= '0;
         scroll_ff      <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ORIGIN_X:    origin_x_ff    <= csr_wdata[CoordW-1:0];
               REG_ORIGIN_Y:    origin_y_ff    <= csr_wdata[CoordW-1:0];
               REG_AREA_WIDTH:  area_width_ff  <= csr_wdata[CoordW-1:0];
               REG_AREA_HEIGHT: area_height_ff <= csr_wdata[CoordW-1:0];
               REG_GLYPH_SCALE: scale_ff       <= csr_wdata[ScaleW-1:0];
               default: ;
            endcase
         end
         cursor_ff <= cursor_in;
         mark_ff   <= mark_in;
         if (cmd.load_char) begin
            scroll_ff <= 1'b0;
         end else if (cmd.latch_scroll) begin
            scroll_ff <= line_next >= 17'(vl_ff);
         end
         if (cmd.load_draw || cmd.load_scroll) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (cmd.load_char) begin
         char_ff <= req_char;
      end
      if (cmd.latch_cpl) begin
         cpl_ff <= (div_quo == '0) ? CoordW'(1) : div_quo[CoordW-1:0];
      end
      if (cmd.latch_vl) begin
         vl_ff <= div_quo[CoordW-1:0];
      end
      if (cmd.calc_draw) begin
         px_ff    <= (sum_x[17:16] != '0) ? '1 : sum_x[PixW-1:0];
         py_ff    <= (sum_y[23:16] != '0) ? '1 : sum_y[PixW-1:0];
         glyph_ff <= (classify(char_ff) == CH_BACKSPACE) ? CHAR_SPACE : char_ff;
      end
      if (cmd.load_draw) begin
         out_kind_ff  <= 1'b0;
         out_last_ff  <= !scroll_ff;
         out_px_ff    <= px_ff;
         out_py_ff    <= py_ff;
         out_glyph_ff <= glyph_ff;
         out_sp_ff    <= '0;
      end else if (cmd.load_scroll) begin
         out_kind_ff  <= 1'b1;
         out_last_ff  <= 1'b1;
         out_px_ff    <= '0;
         out_py_ff    <= '0;
         out_glyph_ff <= '0;
         out_sp_ff    <= sp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, out_sp_ff, out_glyph_ff, out_py_ff, out_px_ff};

   assign sts.req_class      = classify(req_char);
   assign sts.cur_class      = classify(char_ff);
   assign sts.div_done       = div_done;
   assign sts.erase_ok       = cursor_ff > mark_ff;
   assign sts.scroll_hit     = line_next >= 17'(vl_ff);
   assign sts.scroll_pending = scroll_ff;
   assign sts.out_free       = out_free;

   a_scroll_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff) |-> out_last_ff)
      else $error("scroll transaction not marked last");

endmodule

>>> rtl/core/tcce_controller.sv
// Sequencer of the cursor engine: steps each nonzero byte through the divides,
// the cursor update and the result loads. Uses tcce_pkg types.
module tcce_controller import tcce_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      take;

   assign take = req_tvalid && (sts.req_class != CH_NUL);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) state_in = ST_CPL;
         end
         ST_CPL: begin
            if (sts.div_done) state_in = ST_VL;
         end
         ST_VL: begin
            if (sts.div_done) begin
               if (sts.cur_class == CH_BACKSPACE && !sts.erase_ok) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_POS1_START;
               end
            end
         end
         ST_POS1_START: state_in = ST_POS1;
         ST_POS1: begin
            if (sts.div_done) begin
               state_in = (sts.cur_class == CH_BACKSPACE) ? ST_EMIT_DRAW : ST_POS2_START;
            end
         end
         ST_POS2_START: state_in = ST_POS2;
         ST_POS2: begin
            if (sts.div_done) begin
               priority if (sts.cur_class == CH_PRINT) begin
                  state_in = ST_EMIT_DRAW;
               end else if (sts.scroll_hit) begin
                  state_in = ST_EMIT_SCROLL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_DRAW: begin
            if (sts.out_free) state_in = sts.scroll_pending ? ST_EMIT_SCROLL : ST_IDLE;
         end
         ST_EMIT_SCROLL: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.div_sel = DIV_SEL_POS;
      req_tready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (take) begin
               cmd.load_char = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_CPL;
            end
         end
         ST_CPL: begin
            if (sts.div_done) begin
               cmd.latch_cpl = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_VL;
            end
         end
         ST_VL: begin
            if (sts.div_done) begin
               cmd.latch_vl = 1'b1;
               cmd.cur_dec  = (sts.cur_class == CH_BACKSPACE) && sts.erase_ok;
            end
         end
         ST_POS1_START, ST_POS2_START: begin
            cmd.div_start = 1'b1;
         end
         ST_POS1: begin
            if (sts.div_done) begin
               cmd.calc_draw   = 1'b1;
               cmd.cur_inc     = (sts.cur_class == CH_PRINT);
               cmd.cur_newline = (sts.cur_class == CH_NEWLINE);
            end
         end
         ST_POS2: begin
            cmd.latch_scroll = sts.div_done;
         end
         ST_EMIT_DRAW: begin
            cmd.load_draw = sts.out_free;
         end
         ST_EMIT_SCROLL: begin
            cmd.load_scroll = sts.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_draw_needs_glyph: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_DRAW) |->
         (sts.cur_class == CH_BACKSPACE || sts.cur_class == CH_PRINT))
      else $error("draw issued for a byte that does not draw");

endmodule
